FILE: src/sap_pkg.sv
// shared widths, codes and helpers for the schroeder allpass delay block
package sap_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int GAIN_W    = 16;
    localparam int LEN_W     = 13;
    localparam int MAX_DELAY = 4096;
    localparam int ADDR_W    = $clog2(MAX_DELAY);
    localparam int PROD_W    = SAMPLE_W + 2;
    localparam int WIDE_W    = SAMPLE_W + 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = CFG_IDX_W'(1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [GAIN_W-1:0]   t_gain;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [WIDE_W-1:0]   t_wide;

    localparam t_wide SAT_MAX = WIDE_W'((2 ** (SAMPLE_W - 1)) - 1);
    localparam t_wide SAT_MIN = -WIDE_W'(2 ** (SAMPLE_W - 1));

    function automatic t_sample sat_sample(input t_wide v);
        t_sample r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[SAMPLE_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: src/schroeder_allpass_delay.sv
// schroeder allpass filter over a circular delay line, top level
// A sample passes from acceptance to its result in the output register through
// a memory read and hold, then two dependent products (gain times stored
// value, gain times new value) on one bit-serial shift-add multiplier with a
// write-back state between them, then the output register. The next sample
// is taken once the current one has left the multiplier and its result sits
// in the output register, so the block takes no new sample while one is in
// flight; a stalled output holds the next result back and with it the input.
// The delay store is one 4096 x 24 memory; instead of a clearing pass after
// reset, a fill count marks the written prefix and entries beyond it read as
// zero, so the block is ready right after reset.
module schroeder_allpass_delay
    import sap_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_sample              i_sample_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_sample              o_sample_out,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_HOLD = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_WRV  = 3'd4;
    localparam logic [2:0] S_MUL2 = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [LEN_W-1:0]  r_len;
    t_gain             r_gain;
    logic [ADDR_W-1:0] r_ptr;
    logic [LEN_W-1:0]  r_fill;
    logic [ADDR_W-1:0] r_addr;
    t_sample           r_x;
    t_sample           r_h;
    t_sample           r_v;
    t_sample           r_y;
    t_sample           r_rd;
    t_sample           r_out;
    logic              r_out_vld;

    t_sample           mem [MAX_DELAY];

    logic [LEN_W-1:0]  eff_len;
    logic [ADDR_W-1:0] ptr_use;
    logic [LEN_W-1:0]  ptr_inc;
    t_sample           h_val;
    logic              mul_start;
    t_sample           mul_mcand;
    logic              mul_done;
    t_prod             mul_prod;
    logic              out_free;
    logic              in_take;

    sap_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mul_mcand),
        .i_mplier (r_gain),
        .o_done   (mul_done),
        .o_prod   (mul_prod)
    );

    always_comb begin
        eff_len = r_len;
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_DELAY)) begin
            eff_len = LEN_W'(MAX_DELAY);
        end
        ptr_use   = ({1'b0, r_ptr} >= eff_len) ? '0 : r_ptr;
        ptr_inc   = {1'b0, r_addr} + LEN_W'(1);
        h_val     = ({1'b0, r_addr} < r_fill) ? r_rd : '0;
        out_free  = !r_out_vld || !i_stall;
        in_take   = (r_state == S_IDLE) && i_valid;
        mul_start = (r_state == S_HOLD) || (r_state == S_WRV);
        mul_mcand = (r_state == S_HOLD) ? h_val : r_v;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_READ;
            end
            S_READ: n_state = S_HOLD;
            S_HOLD: n_state = S_MUL1;
            S_MUL1: begin
                if (mul_done) n_state = S_WRV;
            end
            S_WRV:  n_state = S_MUL2;
            S_MUL2: begin
                if (mul_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= LEN_W'(1);
            r_gain    <= '0;
            r_ptr     <= '0;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_DELAY_LENGTH: r_len  <= i_cfg_data[LEN_W-1:0];
                    CFG_GAIN:         r_gain <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_WRV) begin
                r_ptr <= (ptr_inc >= eff_len) ? '0 : ptr_inc[ADDR_W-1:0];
                if ({1'b0, r_addr} == r_fill) r_fill <= r_fill + LEN_W'(1);
            end
            if (r_state == S_OUT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_x    <= i_sample_in;
            r_addr <= ptr_use;
        end
        if (r_state == S_HOLD) r_h <= h_val;
        if (r_state == S_MUL1 && mul_done) begin
            r_v <= sat_sample(WIDE_W'(r_x) - WIDE_W'(mul_prod));
        end
        if (r_state == S_MUL2 && mul_done) begin
            r_y <= sat_sample(WIDE_W'(mul_prod) + WIDE_W'(r_h));
        end
        if (r_state == S_OUT && out_free) r_out <= r_y;
    end

    always_ff @(posedge i_clk) begin
        r_rd <= mem[r_addr];
        if (r_state == S_WRV) mem[r_addr] <= r_v;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_vld;
    assign o_sample_out = r_out;

endmodule

FILE: src/sap_mul.sv
// bit-serial signed shift-add multiplier with round half up to q1.23
module sap_mul
    import sap_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_sample i_mcand,
    input  t_gain   i_mplier,
    output logic    o_done,
    output t_prod   o_prod
);

    localparam int CNT_W = $clog2(GAIN_W);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    t_sample                   r_mcand;
    logic [GAIN_W-1:0]         r_mplier;
    logic signed [SAMPLE_W:0]  r_hi;
    logic [GAIN_W-1:0]         r_lo;

    logic                      last;
    logic signed [SAMPLE_W+1:0] addend;
    logic signed [SAMPLE_W+1:0] sum;

    always_comb begin
        last   = (r_cnt == CNT_W'(GAIN_W - 1));
        addend = '0;
        if (r_mplier[0]) begin
            addend = last ? -(PROD_W'(r_mcand)) : PROD_W'(r_mcand);
        end
        sum = {r_hi[SAMPLE_W], r_hi} + addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
            r_hi     <= '0;
            r_lo     <= '0;
        end else if (r_busy) begin
            r_mplier <= {1'b0, r_mplier[GAIN_W-1:1]};
            r_hi     <= sum[SAMPLE_W+1:1];
            r_lo     <= {sum[0], r_lo[GAIN_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo[GAIN_W-1]} + PROD_W'({1'b0, r_lo[GAIN_W-2]});

endmodule
